// File: sv/angle_vector_smoother_defines.svh
// Assertion macros for the angle vector smoother.
`ifndef ANGLE_VECTOR_SMOOTHER_DEFINES_SVH
`define ANGLE_VECTOR_SMOOTHER_DEFINES_SVH

// Checked only out of reset.
`define AVS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define AVS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: sv/avs_pkg.sv
// Types, constants and the arctangent table of the angle vector smoother.
`timescale 1ns / 1ps
`default_nettype none

package avs_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int TAB_IDX_W    = $clog2(TABLE_LEN);

    localparam int DP_W     = 36;   // CORDIC datapath, Q30 with headroom
    localparam int STATE_W  = 18;   // Q2.16 components
    localparam int WEIGHT_W = 16;
    localparam int OUT_W    = 16;
    localparam int ACC_W    = 37;   // filter sum

    localparam logic signed [DP_W-1:0] GAIN_Q30   = 36'sd652032874;
    localparam logic signed [DP_W-1:0] PI_Q30     = 36'sd3373259426;
    localparam logic signed [DP_W-1:0] TWO_PI_Q30 = 36'sd6746518852;
    localparam logic [31:0]            PI_MUL     = 32'd3373259426;

    localparam logic signed [ACC_W-1:0]   STATE_MAX_A = 37'sd131071;
    localparam logic signed [ACC_W-1:0]   STATE_MIN_A = -37'sd131072;
    localparam logic signed [STATE_W-1:0] STATE_MAX   = 18'sd131071;
    localparam logic signed [STATE_W-1:0] STATE_MIN   = -18'sd131072;

    localparam logic [OUT_W-1:0]    OUT_LIMIT    = 16'd51471;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd26214;

    // quadrant codes of the angle
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_ROTATE,
        ST_MAP,
        ST_FILT_CM,
        ST_FILT_CA,
        ST_FILT_SM,
        ST_FILT_SA,
        ST_VINIT,
        ST_VECTOR,
        ST_WRAP,
        ST_DONE
    } t_state;

    function automatic logic signed [DP_W-1:0] arctan_q30(input logic [TAB_IDX_W-1:0] idx);
        logic signed [DP_W-1:0] v;
        case (idx)
            5'd0:    v = 36'sd843314857;
            5'd1:    v = 36'sd497837829;
            5'd2:    v = 36'sd263043837;
            5'd3:    v = 36'sd133525159;
            5'd4:    v = 36'sd67021687;
            5'd5:    v = 36'sd33543516;
            5'd6:    v = 36'sd16775851;
            5'd7:    v = 36'sd8388437;
            5'd8:    v = 36'sd4194283;
            5'd9:    v = 36'sd2097149;
            5'd10:   v = 36'sd1048576;
            5'd11:   v = 36'sd524288;
            5'd12:   v = 36'sd262144;
            5'd13:   v = 36'sd131072;
            5'd14:   v = 36'sd65536;
            5'd15:   v = 36'sd32768;
            5'd16:   v = 36'sd16384;
            5'd17:   v = 36'sd8192;
            5'd18:   v = 36'sd4096;
            5'd19:   v = 36'sd2048;
            5'd20:   v = 36'sd1024;
            5'd21:   v = 36'sd512;
            5'd22:   v = 36'sd256;
            5'd23:   v = 36'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: sv/angle_vector_smoother.sv
// Angle vector smoother: angle code to unit vector, exponential smoothing, vector to angle.
// Sequence per accepted input word: ANGLE, CORDIC_STEPS rotation steps, MAP, the filter states,
//   VINIT, CORDIC_STEPS vectoring steps, WRAP, DONE; vectoring is skipped when the filtered vector is zero.
// A new word is taken only in idle, after the last result is loaded; the single shared CORDIC
//   stage serves both phases, and a stalled result holds the block in DONE. Filter multiplier shared.
// Reset (i_rst_n low, synchronous): filter state cleared, weight back to 26214, idle.
`timescale 1ns / 1ps
`default_nettype none
`include "angle_vector_smoother_defines.svh"

module angle_vector_smoother
    import avs_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input words
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [7:0]          i_angle_high_byte,
    input  wire logic [7:0]          i_angle_low_byte,
    // result words
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [OUT_W-1:0]         o_smoothed_angle,
    // weight register write
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [WEIGHT_W-1:0] i_cfg_smoothing_weight
);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                      r_state, n_state;
    logic [STEP_W-1:0]           r_cnt;
    logic [1:0]                  r_quad;
    logic [11:0]                 r_rem;
    logic signed [DP_W-1:0]      r_x, r_y, r_z;       // shared CORDIC registers
    logic signed [STATE_W-1:0]   r_new_c, r_new_s;    // fresh unit vector, Q2.16
    logic signed [STATE_W-1:0]   r_fc, r_fs;          // filtered vector, Q2.16
    logic signed [ACC_W-1:0]     r_acc;               // w * new sample
    logic [WEIGHT_W-1:0]         r_weight;
    logic                        r_out_valid;
    logic [OUT_W-1:0]            r_out_data;

    // ------------------------------------------------------------------
    // Control strobes
    // ------------------------------------------------------------------
    logic w_accept;
    logic w_out_load;
    logic w_last;
    logic w_zero_vec;

    // ------------------------------------------------------------------
    // Datapath nets
    // ------------------------------------------------------------------
    logic [43:0]                 w_ang_prod;
    logic [43:0]                 w_ang_rnd;
    logic signed [DP_W-1:0]      w_dx, w_dy, w_at;
    logic                        w_sub;               // x -= dx, y += dy, z -= at
    logic signed [DP_W-1:0]      w_rnd_x, w_rnd_y;
    logic signed [STATE_W-1:0]   w_nc, w_ns;
    logic [WEIGHT_W:0]           w_keep;
    logic signed [STATE_W-1:0]   w_mul_a, w_mul_b;
    logic signed [DP_W-1:0]      w_mul_p;
    logic signed [ACC_W-1:0]     w_filt_sum, w_filt_shr;
    logic signed [STATE_W-1:0]   w_filt_sat;
    logic signed [DP_W-1:0]      w_vx, w_vy;
    logic signed [DP_W-1:0]      w_a_neg, w_a1, w_a2;
    logic [DP_W-1:0]             w_rnd_out;
    logic [OUT_W-1:0]            w_units;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (i_valid) n_state = ST_ANGLE;
            ST_ANGLE:   n_state = ST_ROTATE;
            ST_ROTATE:  if (w_last) n_state = ST_MAP;
            ST_MAP:     n_state = ST_FILT_CM;
            ST_FILT_CM: n_state = ST_FILT_CA;
            ST_FILT_CA: n_state = ST_FILT_SM;
            ST_FILT_SM: n_state = ST_FILT_SA;
            ST_FILT_SA: n_state = ST_VINIT;
            // a zero vector skips vectoring: z = 0 rounds to an output of 0
            ST_VINIT:   n_state = w_zero_vec ? ST_WRAP : ST_VECTOR;
            ST_VECTOR:  if (w_last) n_state = ST_WRAP;
            ST_WRAP:    n_state = ST_DONE;
            ST_DONE:    if (w_out_load) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs and strobes
    // ------------------------------------------------------------------
    always_comb begin
        o_stall          = (r_state != ST_IDLE);
        o_valid          = r_out_valid;
        o_smoothed_angle = r_out_data;
        o_cfg_ready      = 1'b1;
        w_accept         = i_valid && (r_state == ST_IDLE);
        // result register frees up when empty or being taken this cycle
        w_out_load       = (r_state == ST_DONE) && (!r_out_valid || !i_stall);
        w_last           = (r_cnt == LAST_STEP);
        w_zero_vec       = (r_fc == '0) && (r_fs == '0);
    end

    // ------------------------------------------------------------------
    // Arithmetic
    // ------------------------------------------------------------------
    always_comb begin
        // angle within quadrant: (rem * pi + 2^12) >> 13, Q30 radians
        w_ang_prod = {32'b0, r_rem} * {12'b0, PI_MUL};
        w_ang_rnd  = w_ang_prod + 44'd4096;

        // one shared CORDIC step; rotation steers by z, vectoring by y
        w_dx  = r_y >>> r_cnt;
        w_dy  = r_x >>> r_cnt;
        w_at  = arctan_q30(TAB_IDX_W'(r_cnt));
        w_sub = (r_state == ST_ROTATE) ? !r_z[DP_W-1] : !(r_y > 0);

        // Q30 -> Q2.16, round half up
        w_rnd_x = r_x + 36'sd8192;
        w_rnd_y = r_y + 36'sd8192;
        w_nc    = w_rnd_x[31:14];
        w_ns    = w_rnd_y[31:14];

        // shared filter multiplier: w * new, then (1 - w) * old
        w_keep = 17'h10000 - {1'b0, r_weight};
        case (r_state)
            ST_FILT_CA: begin
                w_mul_a = {1'b0, w_keep};
                w_mul_b = r_fc;
            end
            ST_FILT_SM: begin
                w_mul_a = {2'b0, r_weight};
                w_mul_b = r_new_s;
            end
            ST_FILT_SA: begin
                w_mul_a = {1'b0, w_keep};
                w_mul_b = r_fs;
            end
            default: begin
                w_mul_a = {2'b0, r_weight};
                w_mul_b = r_new_c;
            end
        endcase
        w_mul_p    = w_mul_a * w_mul_b;
        w_filt_sum = r_acc + ACC_W'(w_mul_p) + 37'sd32768;
        w_filt_shr = w_filt_sum >>> 16;
        if (w_filt_shr > STATE_MAX_A) begin
            w_filt_sat = STATE_MAX;
        end else if (w_filt_shr < STATE_MIN_A) begin
            w_filt_sat = STATE_MIN;
        end else begin
            w_filt_sat = w_filt_shr[STATE_W-1:0];
        end

        // Q2.16 -> Q30 for vectoring
        w_vx = {{4{r_fc[STATE_W-1]}}, r_fc, 14'b0};
        w_vy = {{4{r_fs[STATE_W-1]}}, r_fs, 14'b0};

        // negate and wrap into [0, 2*pi)
        w_a_neg = -r_z;
        w_a1    = w_a_neg[DP_W-1] ? (w_a_neg + TWO_PI_Q30) : w_a_neg;
        w_a2    = (w_a1 >= TWO_PI_Q30) ? (w_a1 - TWO_PI_Q30) : w_a1;

        // Q30 -> 2^-13 rad units, round; a full turn wraps to 0
        w_rnd_out = r_z + 36'sd65536;
        w_units   = (w_rnd_out[32:17] > OUT_LIMIT) ? '0 : w_rnd_out[32:17];
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_weight    <= WEIGHT_RESET;
            r_fc        <= '0;
            r_fs        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_weight <= i_cfg_smoothing_weight;
            end
            if (r_state == ST_ROTATE || r_state == ST_VECTOR) begin
                r_cnt <= w_last ? '0 : r_cnt + 1'b1;
            end
            if (r_state == ST_FILT_CA) begin
                r_fc <= w_filt_sat;
            end
            if (r_state == ST_FILT_SA) begin
                r_fs <= w_filt_sat;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_quad <= i_angle_high_byte[7:6];
            r_rem  <= {i_angle_high_byte[5:0], i_angle_low_byte[7:2]};
        end
        case (r_state)
            ST_ANGLE: begin
                r_x <= GAIN_Q30;
                r_y <= '0;
                r_z <= {5'b0, w_ang_rnd[43:13]};
            end
            ST_ROTATE, ST_VECTOR: begin
                if (w_sub) begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_at;
                end else begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_at;
                end
            end
            ST_MAP: begin
                case (r_quad)
                    QUAD_0: begin
                        r_new_c <= w_nc;
                        r_new_s <= w_ns;
                    end
                    QUAD_1: begin
                        r_new_c <= -w_ns;
                        r_new_s <= w_nc;
                    end
                    QUAD_2: begin
                        r_new_c <= -w_nc;
                        r_new_s <= -w_ns;
                    end
                    default: begin
                        r_new_c <= w_ns;
                        r_new_s <= -w_nc;
                    end
                endcase
            end
            ST_FILT_CM, ST_FILT_SM: begin
                r_acc <= ACC_W'(w_mul_p);
            end
            ST_VINIT: begin
                // fold the left half plane over; start at pi there
                if (r_fc[STATE_W-1]) begin
                    r_x <= -w_vx;
                    r_y <= -w_vy;
                    r_z <= PI_Q30;
                end else begin
                    r_x <= w_vx;
                    r_y <= w_vy;
                    r_z <= '0;
                end
            end
            ST_WRAP: begin
                r_z <= w_a2[DP_W-1] ? '0 : w_a2;
            end
            default: begin
            end
        endcase
        if (w_out_load) begin
            r_out_data <= w_units;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `AVS_ASSERT(a_busy_after_accept, (i_valid && !o_stall) |=> o_stall, "accepted word did not make block busy")
    `AVS_ASSERT(a_cnt_only_iter, (r_cnt != '0) |-> (r_state == ST_ROTATE || r_state == ST_VECTOR), "step counter live outside CORDIC phases")
    `AVS_ASSERT(a_valid_from_done, $rose(o_valid) |-> ($past(r_state) == ST_DONE), "result appeared without finishing a word")
    `AVS_ASSERT_ALWAYS(a_out_range, o_valid |-> (o_smoothed_angle <= OUT_LIMIT), "result beyond a full turn")

endmodule

`default_nettype wire
